@@ sv/ils_pkg.sv @@
// Package for the indexed list store: sizes, operation codes, payload types
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package ils_pkg;

  // Number of elements the store can hold.
  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Widths of the payload fields.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_READ      = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND    = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP_LAST = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd3;
  localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_AT = 3'd5;

  // Answer for "not found" and "invalid index".
  localparam logic [WORD_W-1:0] NEG_ONE = '1;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] index;
    logic signed [WORD_W-1:0] value;
  } ils_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result;
    logic                     ok;
    logic [COUNT_W-1:0]       count;
  } ils_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted request
    logic exec;     // evaluate the request against the current count
    logic rd_done;  // element read for a read request has returned
    logic walk;     // one step of the element walk
    logic fin;      // move the answer into the output register
  } ils_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;   // request needs one element read
    logic is_walk;   // request needs a walk over the elements
    logic walk_end;  // walk finished (match found or elements exhausted)
  } ils_sts_t;

endpackage

@@ sv/ils_dp.sv @@
// Datapath of the indexed list store: request registers, element memory,
// element count, walk pointer and output register.
// Depends on ils_pkg.
module ils_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ils_pkg::ils_in_t  in_data_i,
  input  ils_pkg::ils_cmd_t cmd_i,
  output ils_pkg::ils_sts_t sts_o,
  output ils_pkg::ils_out_t out_data_o
);

  // Request registers.
  logic [ils_pkg::OP_W-1:0]   op_q;
  logic [ils_pkg::WORD_W-1:0] idx_q;
  logic [ils_pkg::WORD_W-1:0] val_q;

  // Control state.
  logic [ils_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [ils_pkg::CNT_W-1:0]  ptr_q, ptr_d;
  logic                       pend_q, pend_d;
  logic [ils_pkg::ADDR_W-1:0] pend_addr_q;

  // Answer registers.
  logic [ils_pkg::WORD_W-1:0] res_q, res_d;
  logic                       ok_q, ok_d;
  ils_pkg::ils_out_t          out_q;

  // Element memory.
  logic [ils_pkg::WORD_W-1:0] mem [ils_pkg::DEPTH];
  logic [ils_pkg::WORD_W-1:0] rdata_q;
  logic                       we;
  logic [ils_pkg::ADDR_W-1:0] waddr;
  logic [ils_pkg::WORD_W-1:0] wdata;
  logic [ils_pkg::ADDR_W-1:0] raddr;

  logic in_range;
  logic has_room;
  logic issue;
  logic hit;
  logic walk_done;
  logic is_search;
  logic is_remove;

  // Decode of the held request.
  assign in_range  = idx_q < ils_pkg::WORD_W'(cnt_q);
  assign has_room  = cnt_q < ils_pkg::CNT_W'(ils_pkg::DEPTH);
  assign is_search = op_q == ils_pkg::OP_SEARCH;
  assign is_remove = op_q == ils_pkg::OP_REMOVE_AT;

  // Walk: one element read issued per cycle, compared or moved in the next cycle.
  assign issue     = ptr_q < cnt_q;
  assign hit       = pend_q && (rdata_q == val_q);
  assign walk_done = !issue && !pend_q;

  assign sts_o.is_read  = (op_q == ils_pkg::OP_READ) && in_range;
  assign sts_o.is_walk  = is_search || (is_remove && in_range);
  assign sts_o.walk_end = walk_done || (is_search && hit);

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.operation;
      idx_q <= in_data_i.index;
      val_q <= in_data_i.value;
    end
  end

  // Next state of count, walk pointer and answer, plus memory port selection.
  always_comb begin
    cnt_d  = cnt_q;
    ptr_d  = ptr_q;
    pend_d = pend_q;
    res_d  = res_q;
    ok_d   = ok_q;
    we     = 1'b0;
    waddr  = pend_addr_q - ils_pkg::ADDR_W'(1);
    wdata  = rdata_q;
    raddr  = ptr_q[ils_pkg::ADDR_W-1:0];

    if (cmd_i.exec) begin
      res_d  = ils_pkg::NEG_ONE;
      ok_d   = 1'b0;
      pend_d = 1'b0;
      raddr  = idx_q[ils_pkg::ADDR_W-1:0];
      case (op_q)
        ils_pkg::OP_APPEND: begin
          if (has_room) begin
            we    = 1'b1;
            waddr = cnt_q[ils_pkg::ADDR_W-1:0];
            wdata = val_q;
            cnt_d = cnt_q + ils_pkg::CNT_W'(1);
            ok_d  = 1'b1;
          end
          res_d = ils_pkg::WORD_W'(cnt_d);
        end
        ils_pkg::OP_DROP_LAST: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - ils_pkg::CNT_W'(1);
            ok_d  = 1'b1;
          end
          res_d = ils_pkg::WORD_W'(cnt_d);
        end
        ils_pkg::OP_SEARCH: begin
          ptr_d = '0;
        end
        ils_pkg::OP_OVERWRITE: begin
          if (in_range) begin
            we    = 1'b1;
            waddr = idx_q[ils_pkg::ADDR_W-1:0];
            wdata = val_q;
            res_d = idx_q;
            ok_d  = 1'b1;
          end
        end
        ils_pkg::OP_REMOVE_AT: begin
          // A walk follows only if the index is below the count, so index plus one fits.
          ptr_d = idx_q[ils_pkg::CNT_W-1:0] + ils_pkg::CNT_W'(1);
          res_d = ils_pkg::WORD_W'(cnt_q);
        end
        default: begin
          res_d = ils_pkg::NEG_ONE;
        end
      endcase
    end else if (cmd_i.rd_done) begin
      res_d = rdata_q;
      ok_d  = 1'b1;
    end else if (cmd_i.walk) begin
      ptr_d  = issue ? ptr_q + ils_pkg::CNT_W'(1) : ptr_q;
      pend_d = issue;
      if (is_search) begin
        if (hit) begin
          res_d = ils_pkg::WORD_W'(pend_addr_q);
          ok_d  = 1'b1;
        end
      end else begin
        // Remove: each returned element moves down one place.
        we = pend_q;
        if (walk_done) begin
          cnt_d = cnt_q - ils_pkg::CNT_W'(1);
          res_d = ils_pkg::WORD_W'(cnt_d);
          ok_d  = 1'b1;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ptr_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ptr_q  <= ptr_d;
      pend_q <= pend_d;
    end
  end

  // Answer and walk address registers.
  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    ok_q        <= ok_d;
    pend_addr_q <= ptr_q[ils_pkg::ADDR_W-1:0];
  end

  // Element memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Output register, loaded when the answer is handed over.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_q.result <= res_q;
      out_q.ok     <= ok_q;
      out_q.count  <= ils_pkg::COUNT_W'(cnt_q);
    end
  end

  assign out_data_o = out_q;

endmodule

@@ sv/ils_ctrl.sv @@
// Controller of the indexed list store: sequences each request through
// evaluation, element read or walk, and hand-over to the output register.
// Depends on ils_pkg.
module ils_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ils_pkg::ils_sts_t sts_i,
  output ils_pkg::ils_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_RDWAIT = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new answer once the old one is gone.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_read) begin
          state_d = ST_RDWAIT;
        end else if (sts_i.is_walk) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_RDWAIT: begin
        cmd_o.rd_done = 1'b1;
        state_d       = ST_FIN;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_end) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on hand-over, cleared when the transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/indexed_list_store.sv @@
// Indexed list store: a list of up to 256 signed 32-bit words with a count,
// serving read, append, drop-last, search, overwrite and remove-at requests,
// one answer per request. Requests are taken one at a time. Append, drop-last,
// overwrite and an invalid request go from evaluation straight to hand-over,
// a read waits for its element first, and search and remove-at walk the stored
// elements through the single read port of the element memory, one element
// per cycle. The answer sits in an output register, so the next request is
// accepted while it waits.
// Depends on ils_pkg, ils_ctrl and ils_dp.
module indexed_list_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ils_pkg::ils_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ils_pkg::ils_out_t out_data_o
);

  ils_pkg::ils_cmd_t cmd;
  ils_pkg::ils_sts_t sts;

  // Request sequencing.
  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Element storage and answer formation.
  ils_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
